FILE: design/lcsw_pkg.sv
package lcsw_pkg;

    localparam int CMD_W      = 3;
    localparam int INDEX_W    = 8;
    localparam int AMOUNT_W   = 16;
    localparam int ROW_W      = 8;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT  = 3'd0,
        CMD_MOVE    = 3'd1,
        CMD_SCROLL  = 3'd2,
        CMD_RECLAMP = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ITEM_COUNT   = 1'b0,
        REG_VISIBLE_ROWS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_CLAMP,
        ST_FIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic srch_step;
        logic clamp;
        logic fit;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_e_t cmd;
        logic   list_empty;
        logic   amount_zero;
        logic   srch_hit;
        logic   srch_miss;
    } dp_status_t;

endpackage

FILE: design/lcsw_req_if.sv
interface lcsw_req_if
    import lcsw_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [INDEX_W-1:0]         index;
    logic                       flag;
    logic signed [AMOUNT_W-1:0] amount;

    modport source (output valid, cmd, index, flag, amount, input ready);
    modport sink (input valid, cmd, index, flag, amount, output ready);
endinterface

FILE: design/lcsw_rsp_if.sv
interface lcsw_rsp_if
    import lcsw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] selected_entry;
    logic             focus_on;
    logic [ROW_W-1:0] last_row;
    logic             found;
    logic             index_visible;

    modport source (output valid, first_row, selected_entry, focus_on, last_row, found,
                    index_visible, input ready);
    modport sink (input valid, first_row, selected_entry, focus_on, last_row, found,
                  index_visible, output ready);
endinterface

FILE: design/list_cursor_scroll_window.sv
// A request is taken while idle and executed; select on a non-empty list and reclamp
// then clamp and fit the window, and move focus walks the active-flag memory at one
// entry per cycle, over up to item count entries, then clamps and fits on a hit. A new
// request waits until the result is loaded; a held, untaken result stalls that load.
// Reset clears the window, cursor, focus flag and item count and sets visible rows to one
// at once; every active flag reads as set until it is written.
module list_cursor_scroll_window
    import lcsw_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lcsw_req_if.sink              req,
    lcsw_rsp_if.source            rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    lcsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lcsw_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cmd            (req.cmd),
        .index          (req.index),
        .flag           (req.flag),
        .amount         (req.amount),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .first_row      (rsp.first_row),
        .selected_entry (rsp.selected_entry),
        .focus_on       (rsp.focus_on),
        .last_row       (rsp.last_row),
        .found          (rsp.found),
        .index_visible  (rsp.index_visible)
    );

endmodule

FILE: design/lcsw_ctrl.sv
module lcsw_ctrl
    import lcsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                unique case (stat.cmd)
                    CMD_SELECT:  state_next = stat.list_empty ? ST_RESULT : ST_CLAMP;
                    CMD_MOVE:    state_next = (stat.list_empty || stat.amount_zero) ?
                                              ST_RESULT : ST_SEARCH;
                    CMD_RECLAMP: state_next = ST_CLAMP;
                    default:     state_next = ST_RESULT;
                endcase
            end
            ST_SEARCH:
            begin
                ctrl.srch_step = 1'b1;
                priority if (stat.srch_hit)
                begin
                    state_next = ST_CLAMP;
                end
                else if (stat.srch_miss)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_CLAMP:
            begin
                ctrl.clamp = 1'b1;
                state_next = ST_FIT;
            end
            ST_FIT:
            begin
                ctrl.fit   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/lcsw_datapath.sv
module lcsw_datapath
    import lcsw_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  ctrl,
    output dp_status_t                 stat,
    input  logic [CMD_W-1:0]           cmd,
    input  logic [INDEX_W-1:0]         index,
    input  logic                       flag,
    input  logic signed [AMOUNT_W-1:0] amount,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic [ROW_W-1:0]           first_row,
    output logic [ROW_W-1:0]           selected_entry,
    output logic                       focus_on,
    output logic [ROW_W-1:0]           last_row,
    output logic                       found,
    output logic                       index_visible
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int SUM_W = AMOUNT_W + 2;

    cmd_e_t                     cmd_reg;
    logic [INDEX_W-1:0]         index_reg;
    logic                       flag_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rows_reg, rows_next;
    logic [CNT_W-1:0]      ws_reg, ws_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic                  focus_reg, focus_next;
    logic                  found_reg, found_next;
    logic                  vis_reg, vis_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]      chk_pos_reg;
    logic                  rd_bit_reg;
    logic                  rd_wv_reg;
    logic [ROW_W-1:0]      first_reg, sel_reg, last_reg;
    logic                  focus_out_reg, found_out_reg, vis_out_reg;

    logic                   mask_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] wv_reg;

    logic [CNT_W-1:0]      n_eff, r_eff, n_m1, top, nxt, idx_ext;
    logic [CNT_W:0]        win_end, win_lim, lim_m1;
    logic signed [SUM_W-1:0] scr_sum;
    logic                  issue, active, wr_ok;
    logic [AW-1:0]         rd_addr, wr_addr;

    assign n_eff   = (32'(count_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : count_reg;
    assign r_eff   = (rows_reg == '0) ? CNT_W'(1) : rows_reg;
    assign n_m1    = n_eff - CNT_W'(1);
    assign top     = (n_eff > r_eff) ? (n_eff - r_eff) : '0;
    assign idx_ext = CNT_W'(index_reg);
    assign win_end = {1'b0, ws_reg} + {1'b0, r_eff};
    assign win_lim = (win_end > {1'b0, n_eff}) ? {1'b0, n_eff} : win_end;
    assign lim_m1  = win_lim - (CNT_W + 1)'(1);
    assign scr_sum = $signed(SUM_W'(ws_reg)) + SUM_W'(amount_reg);

    // Next search position, with wrap-around inside the list.
    always_comb
    begin
        if (!amount_reg[AMOUNT_W-1])
        begin
            nxt = (pos_reg >= n_m1) ? '0 : (pos_reg + CNT_W'(1));
        end
        else
        begin
            nxt = (pos_reg == '0) ? n_m1 : (pos_reg - CNT_W'(1));
        end
    end

    assign issue   = ctrl.srch_step && (iss_reg != n_eff);
    assign rd_addr = AW'(nxt);
    assign wr_addr = AW'(index_reg);
    assign wr_ok   = 32'(index_reg) < MAX_ENTRIES;
    // An entry that was never written since reset reads as active.
    assign active  = rd_wv_reg ? rd_bit_reg : 1'b1;

    assign stat.cmd         = cmd_reg;
    assign stat.list_empty  = (n_eff == '0);
    assign stat.amount_zero = (amount_reg == '0);
    assign stat.srch_hit    = chk_vld_reg && active;
    assign stat.srch_miss   = !chk_vld_reg && (iss_reg == n_eff);

    always_comb
    begin
        count_next   = count_reg;
        rows_next    = rows_reg;
        ws_next      = ws_reg;
        cur_next     = cur_reg;
        focus_next   = focus_reg;
        found_next   = found_reg;
        vis_next     = vis_reg;
        pos_next     = pos_reg;
        iss_next     = iss_reg;
        chk_vld_next = issue;

        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ITEM_COUNT:   count_next = cfg_data;
                REG_VISIBLE_ROWS: rows_next  = cfg_data;
                default:          count_next = count_reg;
            endcase
        end

        if (ctrl.latch)
        begin
            found_next = 1'b0;
            vis_next   = 1'b0;
        end

        if (ctrl.exec)
        begin
            unique case (cmd_reg)
                CMD_SELECT:
                begin
                    if (n_eff != '0)
                    begin
                        cur_next   = (idx_ext >= n_eff) ? n_m1 : idx_ext;
                        focus_next = flag_reg;
                    end
                end
                CMD_MOVE:
                begin
                    pos_next = (cur_reg >= n_eff) ? n_m1 : cur_reg;
                    iss_next = '0;
                end
                CMD_SCROLL:
                begin
                    priority if (n_eff <= r_eff)
                    begin
                        ws_next = '0;
                    end
                    else if (scr_sum < 0)
                    begin
                        ws_next = '0;
                    end
                    else if (scr_sum > $signed(SUM_W'(top)))
                    begin
                        ws_next = top;
                    end
                    else
                    begin
                        ws_next = scr_sum[CNT_W-1:0];
                    end
                end
                CMD_QUERY:
                begin
                    vis_next = (idx_ext < n_eff) && (idx_ext >= ws_reg) &&
                               ({1'b0, idx_ext} < win_end);
                end
                default:
                begin
                    vis_next = 1'b0;
                end
            endcase
        end

        if (issue)
        begin
            pos_next = nxt;
            iss_next = iss_reg + CNT_W'(1);
        end

        if (ctrl.srch_step && stat.srch_hit)
        begin
            cur_next   = chk_pos_reg;
            focus_next = 1'b1;
            found_next = 1'b1;
        end

        if (ctrl.clamp)
        begin
            if (n_eff == '0)
            begin
                ws_next    = '0;
                cur_next   = '0;
                focus_next = 1'b0;
            end
            else
            begin
                cur_next = (cur_reg >= n_eff) ? n_m1 : cur_reg;
                ws_next  = (ws_reg > top) ? top : ws_reg;
            end
        end

        if (ctrl.fit && (n_eff != '0))
        begin
            priority if (cur_reg < ws_reg)
            begin
                ws_next = cur_reg;
            end
            else if ({1'b0, cur_reg} >= win_end)
            begin
                ws_next = cur_reg - r_eff + CNT_W'(1);
            end
            else
            begin
                ws_next = ws_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rows_reg    <= CNT_W'(1);
            ws_reg      <= '0;
            cur_reg     <= '0;
            focus_reg   <= 1'b0;
            found_reg   <= 1'b0;
            vis_reg     <= 1'b0;
            pos_reg     <= '0;
            iss_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rows_reg    <= rows_next;
            ws_reg      <= ws_next;
            cur_reg     <= cur_next;
            focus_reg   <= focus_next;
            found_reg   <= found_next;
            vis_reg     <= vis_next;
            pos_reg     <= pos_next;
            iss_reg     <= iss_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg    <= cmd_e_t'(cmd);
            index_reg  <= index;
            flag_reg   <= flag;
            amount_reg <= amount;
        end
        chk_pos_reg <= nxt;
        if (ctrl.load_out)
        begin
            first_reg     <= ws_reg[ROW_W-1:0];
            sel_reg       <= cur_reg[ROW_W-1:0];
            focus_out_reg <= focus_reg;
            last_reg      <= (n_eff == '0) ? '0 : lim_m1[ROW_W-1:0];
            found_out_reg <= found_reg;
            vis_out_reg   <= vis_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec && (cmd_reg == CMD_WRITE) && wr_ok)
        begin
            mask_mem[wr_addr] <= flag_reg;
        end
        rd_bit_reg <= mask_mem[rd_addr];
        rd_wv_reg  <= wv_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= '0;
        end
        else if (ctrl.exec && (cmd_reg == CMD_WRITE) && wr_ok)
        begin
            wv_reg[wr_addr] <= 1'b1;
        end
    end

    assign first_row      = first_reg;
    assign selected_entry = sel_reg;
    assign focus_on       = focus_out_reg;
    assign last_row       = last_reg;
    assign found          = found_out_reg;
    assign index_visible  = vis_out_reg;

endmodule

FILE: design/lcsw_checker.sv
module lcsw_checker
    import lcsw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [ROW_W-1:0] rsp_first_row,
    input logic [ROW_W-1:0] rsp_selected_entry,
    input logic             rsp_focus_on,
    input logic [ROW_W-1:0] rsp_last_row,
    input logic             rsp_found,
    input logic             rsp_index_visible
);

    // A stalled result stays valid and keeps its rows, selected entry and focus flag.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_row) &&
            $stable(rsp_selected_entry) && $stable(rsp_last_row) && $stable(rsp_focus_on))
        else $error("stalled result changed");

    // Items are worked on one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_found_or_visible: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_found && rsp_index_visible))
        else $error("found and visible both set");

    a_found_shows_focus: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_focus_on)
        else $error("focus hidden after a successful move");

endmodule

bind list_cursor_scroll_window lcsw_checker u_lcsw_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_first_row      (rsp.first_row),
    .rsp_selected_entry (rsp.selected_entry),
    .rsp_focus_on       (rsp.focus_on),
    .rsp_last_row       (rsp.last_row),
    .rsp_found          (rsp.found),
    .rsp_index_visible  (rsp.index_visible)
);
